@@ sv/fba_pkg.sv @@
// ----------------------------------------------------------------------------
// fba_pkg
// shared constants, opcodes, payload structs and state type of the frame
// bitmap allocator
// ----------------------------------------------------------------------------
package fba_pkg;

    localparam int NUM_FRAMES = 4096;
    localparam int WORD_BITS  = 32;
    localparam int MAP_WORDS  = (NUM_FRAMES + WORD_BITS - 1) / WORD_BITS;
    localparam int WORD_AW    = $clog2(MAP_WORDS);
    localparam int BIT_W      = $clog2(WORD_BITS);
    localparam int FRAME_W    = 12;
    localparam int LIMIT_W    = 13;
    localparam int GRP_SIZE   = 8;
    localparam int GRP_NUM    = MAP_WORDS / GRP_SIZE;
    localparam int GRP_W      = $clog2(GRP_NUM);
    localparam int SUB_W      = $clog2(GRP_SIZE);

    localparam logic [LIMIT_W-1:0] LIMIT_RST = LIMIT_W'(NUM_FRAMES);

    localparam logic [1:0] OP_ALLOC = 2'd0;
    localparam logic [1:0] OP_FREE  = 2'd1;
    localparam logic [1:0] OP_TEST  = 2'd2;

    typedef struct packed {
        logic [1:0]         op;
        logic [FRAME_W-1:0] page_frame;
        logic               kernel_page;
        logic               rx_request;
    } t_fba_in;

    typedef struct packed {
        logic [FRAME_W-1:0] new_frame;
        logic               present;
        logic               page_rx;
        logic               user;
        logic               updated;
        logic               full_res;
        logic               in_use;
    } t_fba_out;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_PICK_GRP,
        ST_PICK_WORD,
        ST_MODIFY,
        ST_DONE
    } t_state;

endpackage

@@ sv/fba_ram.sv @@
// ----------------------------------------------------------------------------
// fba_ram
// simple dual-port synchronous ram, one write and one registered read port
// ----------------------------------------------------------------------------
module fba_ram #(
    parameter int DEPTH = 128,
    parameter int WIDTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

@@ sv/frame_bitmap_allocator.sv @@
// ----------------------------------------------------------------------------
// frame_bitmap_allocator
// first-fit physical frame allocator over a usage bitmap held in a ram,
// with a per-word full summary for a short two-level search
// ----------------------------------------------------------------------------
//  channel   direction  handshake                payload
//  cfg       in         i_cfg_wr_en              i_cfg_wr_data (frame_limit)
//  in        in         i_in_valid / o_in_stall  i_in_data  (t_fba_in)
//  out       out        o_out_valid / i_out_stall o_out_data (t_fba_out)
//
//  one item in work at a time; steps from transfer to result in the output
//  register: none for no-op cases; ram read, modify, write for free; ram
//  read and modify for test; summary scan, group pick, word pick, ram read-
//  modify-write for allocate; scan and group pick for a full map. the next
//  transfer can be taken in the cycle after the result is loaded.
//  reset clears the word valid and full summary flags.
//  a stalled result waits in the output register while the next item works.
// ----------------------------------------------------------------------------
module frame_bitmap_allocator (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_wr_en,
    input  logic [fba_pkg::LIMIT_W-1:0]   i_cfg_wr_data,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  fba_pkg::t_fba_in              i_in_data,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output fba_pkg::t_fba_out             o_out_data
);

    fba_pkg::t_state                    r_state, n_state;
    logic [fba_pkg::LIMIT_W-1:0]        r_limit;
    fba_pkg::t_fba_in                   r_item;
    logic [fba_pkg::MAP_WORDS-1:0]      r_vld;
    logic [fba_pkg::MAP_WORDS-1:0]      r_full;
    logic [fba_pkg::MAP_WORDS-1:0]      r_avail;
    logic [fba_pkg::GRP_NUM-1:0]        r_grp;
    logic [fba_pkg::GRP_W-1:0]          r_gsel;
    logic [fba_pkg::WORD_AW-1:0]        r_waddr;
    fba_pkg::t_fba_out                  r_res, n_res;
    logic                               r_out_vld;
    fba_pkg::t_fba_out                  r_out;

    logic                               w_accept;
    logic                               w_is_search;
    logic                               w_is_read;
    logic                               w_slot_free;
    logic                               w_lim_all;
    logic [fba_pkg::WORD_AW-1:0]        w_lim_cnt;
    logic [fba_pkg::MAP_WORDS-1:0]      w_avail;
    logic [fba_pkg::GRP_NUM-1:0]        w_grp_any;
    logic [fba_pkg::GRP_W-1:0]          w_gsel;
    logic [fba_pkg::GRP_SIZE-1:0]       w_grp_bits;
    logic [fba_pkg::SUB_W-1:0]          w_sub;
    logic                               rd_en;
    logic [fba_pkg::WORD_AW-1:0]        rd_addr;
    logic [fba_pkg::WORD_BITS-1:0]      rd_q;
    logic                               wr_en;
    logic [fba_pkg::WORD_BITS-1:0]      wr_data;
    logic [fba_pkg::WORD_BITS-1:0]      w_word;
    logic [fba_pkg::BIT_W-1:0]          w_zero_bit;
    logic [fba_pkg::BIT_W-1:0]          w_bit_idx;
    logic [fba_pkg::WORD_BITS-1:0]      w_mask;

    fba_ram #(
        .DEPTH (fba_pkg::MAP_WORDS),
        .WIDTH (fba_pkg::WORD_BITS)
    ) u_map (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (r_waddr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_q)
    );

    // request decode
    assign w_accept    = i_in_valid && (r_state == fba_pkg::ST_IDLE);
    assign w_is_search = (i_in_data.op == fba_pkg::OP_ALLOC) && (i_in_data.page_frame == '0);
    assign w_is_read   = ((i_in_data.op == fba_pkg::OP_FREE) && (i_in_data.page_frame != '0))
                         || (i_in_data.op == fba_pkg::OP_TEST);
    assign w_slot_free = !r_out_vld || !i_out_stall;

    // searchable words below the limit
    assign w_lim_all = (r_limit >= fba_pkg::LIMIT_RST);
    assign w_lim_cnt = r_limit[fba_pkg::FRAME_W-1:fba_pkg::BIT_W];

    always_comb begin
        for (int w = 0; w < fba_pkg::MAP_WORDS; w++) begin
            w_avail[w] = !r_full[w] && (w_lim_all || (fba_pkg::WORD_AW'(w) < w_lim_cnt));
        end
        for (int g = 0; g < fba_pkg::GRP_NUM; g++) begin
            w_grp_any[g] = |w_avail[g*fba_pkg::GRP_SIZE +: fba_pkg::GRP_SIZE];
        end
    end

    // lowest group with a free word
    always_comb begin
        w_gsel = '0;
        for (int g = fba_pkg::GRP_NUM - 1; g >= 0; g--) begin
            if (r_grp[g]) begin
                w_gsel = fba_pkg::GRP_W'(g);
            end
        end
    end

    // lowest free word inside the chosen group
    assign w_grp_bits = r_avail[r_gsel*fba_pkg::GRP_SIZE +: fba_pkg::GRP_SIZE];

    always_comb begin
        w_sub = '0;
        for (int s = fba_pkg::GRP_SIZE - 1; s >= 0; s--) begin
            if (w_grp_bits[s]) begin
                w_sub = fba_pkg::SUB_W'(s);
            end
        end
    end

    // word modify
    assign w_word    = r_vld[r_waddr] ? rd_q : '0;
    assign w_bit_idx = r_item.page_frame[fba_pkg::BIT_W-1:0];

    always_comb begin
        w_zero_bit = '0;
        for (int b = fba_pkg::WORD_BITS - 1; b >= 0; b--) begin
            if (!w_word[b]) begin
                w_zero_bit = fba_pkg::BIT_W'(b);
            end
        end
    end

    assign w_mask  = fba_pkg::WORD_BITS'(1) << ((r_item.op == fba_pkg::OP_ALLOC) ? w_zero_bit
                                                                                : w_bit_idx);
    assign wr_data = (r_item.op == fba_pkg::OP_ALLOC) ? (w_word | w_mask) : (w_word & ~w_mask);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            fba_pkg::ST_IDLE: begin
                if (w_accept) begin
                    if (w_is_search) begin
                        n_state = fba_pkg::ST_SCAN;
                    end else if (w_is_read) begin
                        n_state = fba_pkg::ST_MODIFY;
                    end else begin
                        n_state = fba_pkg::ST_DONE;
                    end
                end
            end
            fba_pkg::ST_SCAN: begin
                n_state = fba_pkg::ST_PICK_GRP;
            end
            fba_pkg::ST_PICK_GRP: begin
                n_state = (|r_grp) ? fba_pkg::ST_PICK_WORD : fba_pkg::ST_DONE;
            end
            fba_pkg::ST_PICK_WORD: begin
                n_state = fba_pkg::ST_MODIFY;
            end
            fba_pkg::ST_MODIFY: begin
                n_state = fba_pkg::ST_DONE;
            end
            fba_pkg::ST_DONE: begin
                if (w_slot_free) begin
                    n_state = fba_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = fba_pkg::ST_IDLE;
            end
        endcase
    end

    // control outputs
    always_comb begin
        o_in_stall = (r_state != fba_pkg::ST_IDLE);
        rd_en      = 1'b0;
        rd_addr    = i_in_data.page_frame[fba_pkg::FRAME_W-1:fba_pkg::BIT_W];
        wr_en      = 1'b0;
        unique case (r_state)
            fba_pkg::ST_IDLE: begin
                rd_en = w_accept && w_is_read;
            end
            fba_pkg::ST_PICK_WORD: begin
                rd_en   = 1'b1;
                rd_addr = {r_gsel, w_sub};
            end
            fba_pkg::ST_MODIFY: begin
                wr_en = (r_item.op != fba_pkg::OP_TEST);
            end
            default: begin
                rd_en = 1'b0;
            end
        endcase
    end

    // result
    always_comb begin
        n_res = r_res;
        unique case (r_state)
            fba_pkg::ST_IDLE: begin
                n_res           = '0;
                n_res.new_frame = (i_in_data.op == fba_pkg::OP_FREE) ? '0
                                                                     : i_in_data.page_frame;
            end
            fba_pkg::ST_PICK_GRP: begin
                n_res           = '0;
                n_res.new_frame = r_item.page_frame;
                n_res.full_res  = 1'b1;
            end
            fba_pkg::ST_MODIFY: begin
                n_res = '0;
                case (r_item.op)
                    fba_pkg::OP_ALLOC: begin
                        n_res.new_frame = {r_waddr, w_zero_bit};
                        n_res.present   = 1'b1;
                        n_res.page_rx   = r_item.rx_request;
                        n_res.user      = !r_item.kernel_page;
                        n_res.updated   = 1'b1;
                    end
                    fba_pkg::OP_FREE: begin
                        n_res.updated = 1'b1;
                    end
                    default: begin
                        n_res.new_frame = r_item.page_frame;
                        n_res.in_use    = w_word[w_bit_idx];
                    end
                endcase
            end
            default: begin
                n_res = r_res;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= fba_pkg::ST_IDLE;
            r_limit   <= fba_pkg::LIMIT_RST;
            r_vld     <= '0;
            r_full    <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_wr_en) begin
                r_limit <= i_cfg_wr_data;
            end
            if (wr_en) begin
                r_vld[r_waddr]  <= 1'b1;
                r_full[r_waddr] <= &wr_data;
            end
            if ((r_state == fba_pkg::ST_DONE) && w_slot_free) begin
                r_out_vld <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_item <= i_in_data;
        end
        if (r_state == fba_pkg::ST_SCAN) begin
            r_avail <= w_avail;
            r_grp   <= w_grp_any;
        end
        if (r_state == fba_pkg::ST_PICK_GRP) begin
            r_gsel <= w_gsel;
        end
        if (rd_en) begin
            r_waddr <= rd_addr;
        end
        r_res <= n_res;
        if ((r_state == fba_pkg::ST_DONE) && w_slot_free) begin
            r_out <= r_res;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

    // the chosen word must still hold a free frame
    a_alloc_word_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == fba_pkg::ST_MODIFY && r_item.op == fba_pkg::OP_ALLOC)
        |-> (!r_full[r_waddr] && (w_word != '1)))
        else $error("allocation picked a full word");

    a_present_updated: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && r_out.present) |-> (r_out.updated && !r_out.full_res))
        else $error("present result without update");

    a_full_no_change: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && r_out.full_res) |-> (!r_out.updated && !r_out.present))
        else $error("full result changed the page");

    a_done_waits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == fba_pkg::ST_DONE && !w_slot_free) |=> (r_state == fba_pkg::ST_DONE))
        else $error("result dropped while output register busy");

endmodule
